>>> rtl/uptsp_pkg.sv
// Package for the USB port thermal short protection block.
// Holds the register indexes, request kinds, counter and temperature constants.
// No dependencies.
package uptsp_pkg;

    typedef enum logic [2:0] {
        REG_USB_THRESHOLD      = 3'd0,
        REG_OPEN_SWITCH_DIFF   = 3'd1,
        REG_OPEN_HIZ_DIFF      = 3'd2,
        REG_CLOSE_SWITCH_DIFF  = 3'd3,
        REG_FAST_INTERVAL_DIFF = 3'd4,
        REG_HIZ_REPORT_ENABLE  = 3'd5
    } reg_index_t;

    typedef enum logic {
        REQ_CHECK = 1'b0,
        REQ_START = 1'b1
    } req_type_t;

    typedef logic signed [11:0] count_t;
    typedef logic signed [8:0]  temp_t;
    typedef logic signed [9:0]  diff_t;

    localparam count_t COUNT_INIT  = 12'sd1100;
    localparam count_t COUNT_END   = 12'sd1001;
    localparam count_t COUNT_IDLE  = -12'sd1;
    localparam count_t COUNT_START = 12'sd0;

    localparam temp_t TEMP_UPPER = 9'sd100;
    localparam temp_t TEMP_LOWER = -9'sd30;

    localparam logic signed [7:0] USB_THRESHOLD_RESET = 8'sd40;

endpackage

>>> rtl/usb_port_thermal_short_protect.sv
// USB port short-circuit thermal monitor, top level.
// Depends on uptsp_pkg.
//
// Usage:
//   s_axis carries start requests (tuser = 1) and check ticks (tuser = 0)
//   with the USB and battery temperatures and charger status in tdata.
//   m_axis returns one status word per accepted transaction.
//   cfg writes the six configuration registers by index; ready is always high.
// Timing: the status for a transaction is on m_axis in the cycle after it is
//   accepted. Throughput: one transaction per cycle unless m_axis stalls; all
//   state moves by one compare/count step between input and result register.
// Stall: s_axis_tready stays high while the result register is empty or
//   being taken in the same cycle; while m_axis is stalled with a result
//   pending, new input is held off and the result stays unchanged.
// Reset: asynchronous, active low. Monitoring off, counter at 1100, all
//   protection cleared, both one-shot reports armed, registers at defaults
//   (threshold 40 C, differences 0, hiz report disabled).
module usb_port_thermal_short_protect
    import uptsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // port_tc[8:0], batt_tc[17:9],
                                       // unplugged[18], direct_charge_idle[19]
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // switch_open, hiz_active, protect_latched,
                                       // protect_now, fast_check, report_short,
                                       // report_hiz, sample_ignored, monitoring
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration
    logic signed [7:0] usb_thr_reg, open_sw_reg, open_hiz_reg, close_sw_reg, fast_diff_reg;
    logic              hiz_rep_en_reg;

    // run state
    logic   mon_reg, mon_next;
    count_t cnt_reg, cnt_next;
    logic   lat_reg, lat_next;
    logic   rt_reg, rt_next;
    logic   hiz_reg, hiz_next;
    logic   short_arm_reg, short_arm_next;
    logic   hiz_arm_reg, hiz_arm_next;
    logic   sw_reg, sw_next;
    logic   fast_reg, fast_next;

    logic        out_valid_reg;
    logic [15:0] out_data_reg, out_data_next;

    logic   accept;
    temp_t  usb_t, bat_t;
    diff_t  diff;
    logic   removed, dc_idle, hot, hiz_hit, sw_hit, temps_ok;
    logic   rep_short, rep_hiz, ignored;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign usb_t   = s_axis_tdata[8:0];
    assign bat_t   = s_axis_tdata[17:9];
    assign removed = s_axis_tdata[18];
    assign dc_idle = s_axis_tdata[19];
    assign diff    = 10'(usb_t) - 10'(bat_t);

    assign temps_ok = (usb_t >= TEMP_LOWER) && (usb_t <= TEMP_UPPER)
                   && (bat_t >= TEMP_LOWER) && (bat_t <= TEMP_UPPER);
    assign hot      = 10'(usb_t) >= 10'(usb_thr_reg);
    assign hiz_hit  = hot && (diff >= 10'(open_hiz_reg));
    assign sw_hit   = hot && (diff >= 10'(open_sw_reg));

    always_comb
    begin
        mon_next       = mon_reg;
        cnt_next       = cnt_reg;
        lat_next       = lat_reg;
        rt_next        = rt_reg;
        hiz_next       = hiz_reg;
        short_arm_next = short_arm_reg;
        hiz_arm_next   = hiz_arm_reg;
        sw_next        = sw_reg;
        fast_next      = fast_reg;
        rep_short      = 1'b0;
        rep_hiz        = 1'b0;
        ignored        = 1'b0;

        if (req_type_t'(s_axis_tuser) == REQ_START)
        begin
            if (!mon_reg)
            begin
                mon_next = 1'b1;
                cnt_next = COUNT_INIT;
            end
        end
        else if (mon_reg)
        begin
            if (cnt_reg == COUNT_IDLE && removed && dc_idle)
            begin
                short_arm_next = 1'b1;
                sw_next        = 1'b0;
                fast_next      = 1'b0;
                lat_next       = 1'b0;
                cnt_next       = COUNT_INIT;
                mon_next       = 1'b0;
            end
            else if (temps_ok)
            begin
                // threshold tests and one-shot reports
                if (hiz_hit && hiz_rep_en_reg && hiz_arm_reg)
                begin
                    rep_hiz      = 1'b1;
                    hiz_arm_next = 1'b0;
                end
                if (sw_hit)
                begin
                    rt_next = 1'b1;
                    if (short_arm_reg)
                    begin
                        rep_short      = 1'b1;
                        short_arm_next = 1'b0;
                    end
                end

                // fast/slow interval counter
                priority if (diff > 10'(fast_diff_reg))
                begin
                    fast_next = 1'b1;
                    cnt_next  = COUNT_START;
                end
                else if (cnt_reg > COUNT_END)
                begin
                    cnt_next  = cnt_reg - 12'sd1;
                    fast_next = 1'b1;
                end
                else if (cnt_reg == COUNT_END)
                begin
                    cnt_next  = COUNT_IDLE;
                    fast_next = 1'b0;
                end
                else if (cnt_reg >= COUNT_START)
                begin
                    cnt_next  = cnt_reg + 12'sd1;
                    fast_next = 1'b1;
                end
                else
                begin
                    fast_next = 1'b0;
                    lat_next  = 1'b0;
                end

                // apply and release
                if (hiz_hit)
                    hiz_next = 1'b1;
                if (sw_hit)
                begin
                    lat_next = 1'b1;
                    rt_next  = 1'b1;
                    sw_next  = 1'b1;
                end
                else if (diff <= 10'(close_sw_reg))
                begin
                    if (lat_next)
                    begin
                        sw_next = 1'b0;
                        rt_next = 1'b0;
                    end
                    hiz_next = 1'b0;
                end
            end
            else
            begin
                ignored = 1'b1;
            end
        end

        out_data_next = {7'b0, mon_next, ignored, rep_hiz, rep_short, fast_next,
                         rt_next, lat_next, hiz_next, sw_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usb_thr_reg    <= USB_THRESHOLD_RESET;
            open_sw_reg    <= '0;
            open_hiz_reg   <= '0;
            close_sw_reg   <= '0;
            fast_diff_reg  <= '0;
            hiz_rep_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_USB_THRESHOLD:      usb_thr_reg    <= cfg_data;
                REG_OPEN_SWITCH_DIFF:   open_sw_reg    <= cfg_data;
                REG_OPEN_HIZ_DIFF:      open_hiz_reg   <= cfg_data;
                REG_CLOSE_SWITCH_DIFF:  close_sw_reg   <= cfg_data;
                REG_FAST_INTERVAL_DIFF: fast_diff_reg  <= cfg_data;
                REG_HIZ_REPORT_ENABLE:  hiz_rep_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_reg       <= 1'b0;
            cnt_reg       <= COUNT_INIT;
            lat_reg       <= 1'b0;
            rt_reg        <= 1'b0;
            hiz_reg       <= 1'b0;
            short_arm_reg <= 1'b1;
            hiz_arm_reg   <= 1'b1;
            sw_reg        <= 1'b0;
            fast_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mon_reg       <= mon_next;
                cnt_reg       <= cnt_next;
                lat_reg       <= lat_next;
                rt_reg        <= rt_next;
                hiz_reg       <= hiz_next;
                short_arm_reg <= short_arm_next;
                hiz_arm_reg   <= hiz_arm_next;
                sw_reg        <= sw_next;
                fast_reg      <= fast_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    // counter only ever holds idle or a value in the active window
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == COUNT_IDLE) || (cnt_reg >= COUNT_START && cnt_reg <= COUNT_INIT))
        else $error("check counter out of range");

    // counter parks at its initial value whenever monitoring is off
    a_cnt_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !mon_reg |-> cnt_reg == COUNT_INIT)
        else $error("counter moved while not monitoring");

    // idle counter means slow checking
    a_idle_slow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == COUNT_IDLE |-> !fast_reg)
        else $error("fast checking with idle counter");

    // a pending short report has already disarmed its one-shot
    a_short_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[5]) |-> !short_arm_reg)
        else $error("short report still armed");

    // an ignored sample only comes from a monitoring run
    a_ignored_mon: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[7]) |-> out_data_reg[8])
        else $error("ignored sample while not monitoring");

endmodule
